FILE: rtl/gps_pkg.sv
// package for the polar gaussian sampler: payload structs, constants, step functions
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
package gps_pkg;

  localparam int UNIFORM_BITS_DEF = 32;
  localparam int LOG_STEPS        = 28;
  localparam int SQRT_STEPS       = 32;
  localparam int DIV_STEPS        = 32;
  localparam int FIFO_DEPTH       = 4;
  localparam int CFG_IDX_W        = 8;

  // 2 ln 2 in q.28
  localparam logic [28:0] TWO_LN2_Q28 = 29'd372130559;

  localparam logic [CFG_IDX_W-1:0] REG_MEAN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STD  = 8'd1;

  typedef struct packed {
    logic [31:0] uniform_a;
    logic [31:0] uniform_b;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sample_value;
    logic               last_of_pair;
  } out_item_t;

  typedef struct packed {
    logic single;
    logic neg_x;
    logic neg_y;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [62:0] s;
  } work_t;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] r;
  } sq_t;

  // one squaring step of the log2 fraction: {bit, new mantissa}
  function automatic logic [31:0] log_step(logic [30:0] m);
    logic [61:0] sq;
    sq = {31'b0, m} * {31'b0, m};
    return sq[61] ? {1'b1, sq[61:31]} : {1'b0, sq[60:30]};
  endfunction

  // one digit of the integer square root
  function automatic sq_t sqrt_step(sq_t a, logic [63:0] bit_w);
    sq_t        o;
    logic [64:0] sum;
    sum = {1'b0, a.r} + {1'b0, bit_w};
    if ({1'b0, a.v} >= sum) begin
      o.v = a.v - sum[63:0];
      o.r = (a.r >> 1) + bit_w;
    end else begin
      o.v = a.v;
      o.r = a.r >> 1;
    end
    return o;
  endfunction

  // one restoring division step: {new remainder, quotient bit}
  function automatic logic [32:0] div_step(logic [31:0] rem, logic nbit, logic [31:0] d);
    logic [32:0] t;
    logic [32:0] diff;
    t    = {rem, nbit};
    diff = t - {1'b0, d};
    return (t >= {1'b0, d}) ? {diff[31:0], 1'b1} : {t[31:0], 1'b0};
  endfunction

endpackage

FILE: rtl/gaussian_polar_sampler.sv
// polar gaussian sampler: an accepted pair passes the front-end registers, the queue and
// the back pipeline before its first result; a kept pair gives two results on the output,
// a zero-deviation item one, a rejected pair none; one input item per cycle unless stalled.
// the output port carrying one result per cycle sets the sustained rate.
// synchronous active-low reset empties all stages; mean resets to 0, deviation to 1.0
`timescale 1ns / 1ps
module gaussian_polar_sampler #(
  parameter int UNIFORM_BITS = gps_pkg::UNIFORM_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  gps_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output gps_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);
  import gps_pkg::*;

  logic signed [31:0] mean_r;
  logic [30:0]        std_r;
  logic               fq_valid, fq_ready, bq_valid, bq_ready;
  work_t              fq_data, bq_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= '0;
      std_r  <= 31'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MEAN: mean_r <= cfg_data;
        REG_STD:  std_r  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  gps_front #(.UNIFORM_BITS(UNIFORM_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .std_zero (std_r == 31'd0),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  gps_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (bq_valid),
    .pop_ready  (bq_ready),
    .pop_data   (bq_data)
  );

  gps_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (bq_valid),
    .q_ready    (bq_ready),
    .q_data     (bq_data),
    .mean_value (mean_r),
    .std_dev    (std_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

FILE: rtl/gps_front.sv
// front end: maps uniforms to |x|,|y|, forms s and drops rejected pairs
// depends on gps_pkg
`timescale 1ns / 1ps
module gps_front #(
  parameter int UNIFORM_BITS = gps_pkg::UNIFORM_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  gps_pkg::in_item_t in_data,
  input  logic             std_zero,
  output logic             q_valid,
  input  logic             q_ready,
  output gps_pkg::work_t   q_data
);
  import gps_pkg::*;

  localparam int SHL = (UNIFORM_BITS < 32) ? 32 - UNIFORM_BITS : 0;
  localparam int SHR = (UNIFORM_BITS > 32) ? UNIFORM_BITS - 32 : 0;

  function automatic logic [31:0] to_q32(logic [31:0] u);
    return (u << SHL) >> SHR;
  endfunction

  function automatic logic [31:0] mid_offset(logic [31:0] uq);
    return uq[31] ? {1'b0, uq[30:0]} : (32'h8000_0000 - uq);
  endfunction

  logic        v1_r, v2_r;
  side_t       sd1_r, sd2_r;
  logic [31:0] ax1_r, ay1_r, ax2_r, ay2_r;
  logic [62:0] sqx2_r, sqy2_r;
  logic [31:0] ua, ub;
  logic [63:0] s_sum;
  logic        reject, en1, en2;

  assign ua = to_q32(in_data.uniform_a);
  assign ub = to_q32(in_data.uniform_b);

  assign s_sum  = {1'b0, sqx2_r} + {1'b0, sqy2_r};
  assign reject = !sd2_r.single && (s_sum == 64'd0 || s_sum > 64'h4000_0000_0000_0000);

  assign en2      = !v2_r || q_ready || reject;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  assign q_valid        = v2_r && !reject;
  assign q_data.side    = sd2_r;
  assign q_data.ax      = ax2_r;
  assign q_data.ay      = ay2_r;
  assign q_data.s       = s_sum[62:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      sd1_r.single <= std_zero;
      sd1_r.neg_x  <= ~ua[31];
      sd1_r.neg_y  <= ~ub[31];
      ax1_r        <= mid_offset(ua);
      ay1_r        <= mid_offset(ub);
    end
    if (en2) begin
      sd2_r  <= sd1_r;
      ax2_r  <= ax1_r;
      ay2_r  <= ay1_r;
      sqx2_r <= {31'b0, ax1_r} * {31'b0, ax1_r};
      sqy2_r <= {31'b0, ay1_r} * {31'b0, ay1_r};
    end
  end

endmodule

FILE: rtl/gps_fifo.sv
// small queue between front end and back end
// depends on gps_pkg
`timescale 1ns / 1ps
module gps_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  gps_pkg::work_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output gps_pkg::work_t pop_data
);
  import gps_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);

  work_t           mem [0:FIFO_DEPTH-1];
  logic [AW-1:0]   wp_r, rp_r;
  logic [AW:0]     cnt_r;
  logic            push, pop;

  assign push_ready = cnt_r != (AW+1)'(FIFO_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_data;
  end

endmodule

FILE: rtl/gps_back.sv
// back end: log2 by squaring, two square roots, two dividers, scaling and result output
// depends on gps_pkg
`timescale 1ns / 1ps
module gps_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  gps_pkg::work_t      q_data,
  input  logic signed [31:0]  mean_value,
  input  logic [30:0]         std_dev,
  output logic                out_valid,
  input  logic                out_ready,
  output gps_pkg::out_item_t  out_data
);
  import gps_pkg::*;

  localparam int NL = LOG_STEPS;
  localparam int NQ = SQRT_STEPS;
  localparam int ND = DIV_STEPS;

  logic adv;

  logic        s0_v_r, s1_v_r;
  work_t       s0_r, s1_r;
  logic [5:0]  s1_p_r, p_nxt;

  // normalize
  logic [62:0] mn;
  logic [4:0]  k_nxt;
  logic [63:0] sn_nxt, axk_nxt, ayk_nxt;

  // log2 chain
  logic          lg_v_r  [0:NL];
  logic [30:0]   lg_m_r  [0:NL];
  logic [NL-1:0] lg_f_r  [0:NL];
  logic [5:0]    lg_p_r  [0:NL];
  logic [63:0]   lg_sn_r [0:NL];
  logic [63:0]   lg_ax_r [0:NL];
  logic [63:0]   lg_ay_r [0:NL];
  side_t         lg_sd_r [0:NL];
  logic [31:0]   lg_sq    [0:NL-1];
  logic [30:0]   lg_m_nxt [0:NL-1];
  logic [NL-1:0] lg_f_nxt [0:NL-1];

  // -2 ln s
  logic [34:0] lval;
  logic [63:0] tprod;

  // square roots
  logic        sq_v_r  [0:NQ];
  sq_t         sg_r    [0:NQ];
  sq_t         ss_r    [0:NQ];
  logic [63:0] sq_ax_r [0:NQ];
  logic [63:0] sq_ay_r [0:NQ];
  side_t       sq_sd_r [0:NQ];
  sq_t         sg_nxt  [0:NQ-1];
  sq_t         ss_nxt  [0:NQ-1];

  // dividers
  logic        dv_v_r  [0:ND];
  logic [31:0] dv_rx_r [0:ND];
  logic [31:0] dv_ry_r [0:ND];
  logic [31:0] dv_qx_r [0:ND];
  logic [31:0] dv_qy_r [0:ND];
  logic [31:0] dv_d_r  [0:ND];
  logic [31:0] dv_g_r  [0:ND];
  logic [1:0]  dv_nx_r [0:ND];
  logic [1:0]  dv_ny_r [0:ND];
  side_t       dv_sd_r [0:ND];
  logic [32:0] dx_nxt  [0:ND-1];
  logic [32:0] dy_nxt  [0:ND-1];

  // scaling
  logic        f1_v_r, f2_v_r;
  side_t       f1_sd_r, f2_sd_r;
  logic [33:0] f1_zx_r, f1_zy_r;
  logic [36:0] f2_vx_r, f2_vy_r;
  logic [63:0] px, py;
  logic [64:0] qx, qy;

  // output register
  logic               tail_v_r, tail_ph_r, tail_single_r;
  logic signed [31:0] tail_x_r, tail_y_r;
  logic               out_last;

  function automatic logic signed [31:0] sat_sum(logic signed [31:0] m, logic [36:0] v,
                                                 logic neg);
    logic signed [38:0] sum;
    logic signed [38:0] sv;
    sv  = $signed({2'b00, v});
    sum = {{7{m[31]}}, m} + (neg ? -sv : sv);
    if (sum > 39'sd2147483647) return 32'sh7FFF_FFFF;
    if (sum < -39'sd2147483648) return 32'sh8000_0000;
    return sum[31:0];
  endfunction

  assign out_last  = tail_ph_r || tail_single_r;
  assign adv       = !tail_v_r || (out_ready && out_last);
  assign q_ready   = adv;
  assign out_valid = tail_v_r;
  assign out_data.sample_value = tail_ph_r ? tail_y_r : tail_x_r;
  assign out_data.last_of_pair = out_last;

  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < 63; i++) begin
      if (s0_r.s[i]) p_nxt = 6'(i);
    end
  end

  always_comb begin
    mn      = (s1_p_r >= 6'd30) ? (s1_r.s >> (s1_p_r - 6'd30)) : (s1_r.s << (6'd30 - s1_p_r));
    k_nxt   = (s1_p_r >= 6'd60) ? 5'd0 : 5'((6'd61 - s1_p_r) >> 1);
    sn_nxt  = {1'b0, s1_r.s} << {k_nxt, 1'b0};
    axk_nxt = {32'b0, s1_r.ax} << k_nxt;
    ayk_nxt = {32'b0, s1_r.ay} << k_nxt;
  end

  always_comb begin
    for (int j = 0; j < NL; j++) begin
      lg_sq[j]    = log_step(lg_m_r[j]);
      lg_m_nxt[j] = lg_sq[j][30:0];
      lg_f_nxt[j] = lg_f_r[j] |
                    (lg_sq[j][31] ? (NL'(1) << (NL - 1 - j)) : '0);
    end
  end

  always_comb begin
    lval  = ({29'b0, 6'd62 - lg_p_r[NL]} << 28) - 35'(lg_f_r[NL]);
    tprod = {29'b0, lval} * {35'b0, TWO_LN2_Q28};
  end

  always_comb begin
    for (int j = 0; j < NQ; j++) begin
      sg_nxt[j] = sqrt_step(sg_r[j], 64'd1 << (62 - 2 * j));
      ss_nxt[j] = sqrt_step(ss_r[j], 64'd1 << (62 - 2 * j));
    end
  end

  // quotient bits beyond the top two numerator bits shift in zeros
  always_comb begin
    for (int j = 0; j < ND; j++) begin
      dx_nxt[j] = div_step(dv_rx_r[j], (j == 0) ? dv_nx_r[j][1] :
                           (j == 1) ? dv_nx_r[j][0] : 1'b0, dv_d_r[j]);
      dy_nxt[j] = div_step(dv_ry_r[j], (j == 0) ? dv_ny_r[j][1] :
                           (j == 1) ? dv_ny_r[j][0] : 1'b0, dv_d_r[j]);
    end
  end

  assign px = {32'b0, dv_qx_r[ND]} * {32'b0, dv_g_r[ND]};
  assign py = {32'b0, dv_qy_r[ND]} * {32'b0, dv_g_r[ND]};
  assign qx = {31'b0, f1_zx_r} * {34'b0, std_dev};
  assign qy = {31'b0, f1_zy_r} * {34'b0, std_dev};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      for (int j = 0; j <= NL; j++) lg_v_r[j] <= 1'b0;
      for (int j = 0; j <= NQ; j++) sq_v_r[j] <= 1'b0;
      for (int j = 0; j <= ND; j++) dv_v_r[j] <= 1'b0;
      f1_v_r    <= 1'b0;
      f2_v_r    <= 1'b0;
      tail_v_r  <= 1'b0;
      tail_ph_r <= 1'b0;
    end else begin
      if (adv) begin
        s0_v_r    <= q_valid;
        s1_v_r    <= s0_v_r;
        lg_v_r[0] <= s1_v_r;
        for (int j = 0; j < NL; j++) lg_v_r[j+1] <= lg_v_r[j];
        sq_v_r[0] <= lg_v_r[NL];
        for (int j = 0; j < NQ; j++) sq_v_r[j+1] <= sq_v_r[j];
        dv_v_r[0] <= sq_v_r[NQ];
        for (int j = 0; j < ND; j++) dv_v_r[j+1] <= dv_v_r[j];
        f1_v_r    <= dv_v_r[ND];
        f2_v_r    <= f1_v_r;
        tail_v_r  <= f2_v_r;
        tail_ph_r <= 1'b0;
      end else if (out_ready) begin
        tail_ph_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r   <= q_data;
      s1_r   <= s0_r;
      s1_p_r <= p_nxt;

      lg_m_r[0]  <= mn[30:0];
      lg_f_r[0]  <= '0;
      lg_p_r[0]  <= s1_p_r;
      lg_sn_r[0] <= sn_nxt;
      lg_ax_r[0] <= axk_nxt;
      lg_ay_r[0] <= ayk_nxt;
      lg_sd_r[0] <= s1_r.side;
      for (int j = 0; j < NL; j++) begin
        lg_m_r[j+1]  <= lg_m_nxt[j];
        lg_f_r[j+1]  <= lg_f_nxt[j];
        lg_p_r[j+1]  <= lg_p_r[j];
        lg_sn_r[j+1] <= lg_sn_r[j];
        lg_ax_r[j+1] <= lg_ax_r[j];
        lg_ay_r[j+1] <= lg_ay_r[j];
        lg_sd_r[j+1] <= lg_sd_r[j];
      end

      sg_r[0].v  <= {tprod[63:28], 28'b0};
      sg_r[0].r  <= '0;
      ss_r[0].v  <= lg_sn_r[NL];
      ss_r[0].r  <= '0;
      sq_ax_r[0] <= lg_ax_r[NL];
      sq_ay_r[0] <= lg_ay_r[NL];
      sq_sd_r[0] <= lg_sd_r[NL];
      for (int j = 0; j < NQ; j++) begin
        sg_r[j+1]    <= sg_nxt[j];
        ss_r[j+1]    <= ss_nxt[j];
        sq_ax_r[j+1] <= sq_ax_r[j];
        sq_ay_r[j+1] <= sq_ay_r[j];
        sq_sd_r[j+1] <= sq_sd_r[j];
      end

      dv_rx_r[0] <= 32'(sq_ax_r[NQ] >> 2);
      dv_ry_r[0] <= 32'(sq_ay_r[NQ] >> 2);
      dv_qx_r[0] <= '0;
      dv_qy_r[0] <= '0;
      dv_d_r[0]  <= ss_r[NQ].r[31:0];
      dv_g_r[0]  <= sg_r[NQ].r[31:0];
      dv_nx_r[0] <= sq_ax_r[NQ][1:0];
      dv_ny_r[0] <= sq_ay_r[NQ][1:0];
      dv_sd_r[0] <= sq_sd_r[NQ];
      for (int j = 0; j < ND; j++) begin
        dv_rx_r[j+1] <= dx_nxt[j][32:1];
        dv_ry_r[j+1] <= dy_nxt[j][32:1];
        dv_qx_r[j+1] <= {dv_qx_r[j][30:0], dx_nxt[j][0]};
        dv_qy_r[j+1] <= {dv_qy_r[j][30:0], dy_nxt[j][0]};
        dv_d_r[j+1]  <= dv_d_r[j];
        dv_g_r[j+1]  <= dv_g_r[j];
        dv_nx_r[j+1] <= dv_nx_r[j];
        dv_ny_r[j+1] <= dv_ny_r[j];
        dv_sd_r[j+1] <= dv_sd_r[j];
      end

      f1_zx_r <= px[63:30];
      f1_zy_r <= py[63:30];
      f1_sd_r <= dv_sd_r[ND];
      f2_vx_r <= qx[64:28];
      f2_vy_r <= qy[64:28];
      f2_sd_r <= f1_sd_r;

      tail_single_r <= f2_sd_r.single;
      tail_x_r      <= f2_sd_r.single ? mean_value : sat_sum(mean_value, f2_vx_r, f2_sd_r.neg_x);
      tail_y_r      <= sat_sum(mean_value, f2_vy_r, f2_sd_r.neg_y);
    end
  end

  a_phase_pair : assert property (@(posedge clk) disable iff (!rst_n)
    tail_ph_r |-> tail_v_r && !tail_single_r)
    else $error("second result phase without a two-result item");

  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s0_v_r) && $stable(f2_v_r) && $stable(dv_v_r[ND]))
    else $error("back pipeline moved while stalled");

  a_second_done : assert property (@(posedge clk) disable iff (!rst_n)
    (tail_ph_r && out_ready) |=> !tail_ph_r)
    else $error("second result not retired");

endmodule
